// File: hdl/midi_clk_pkg.sv
// midi_clk_pkg: widths, event codes and sequencer states for the midi beat clock generator
// no dependencies; imported by midi_clock_generator
package midi_clk_pkg;

    localparam int BLOCK_W   = 13;
    localparam int TEMPO_W   = 18;
    localparam int BEAT_W    = 28;
    localparam int RATE_W    = 18;
    localparam int POS_W     = 14;
    localparam int OFFSET_W  = 12;
    localparam int PROD_W    = TEMPO_W + BLOCK_W;
    localparam int DEN_W     = 29;
    localparam int QUOT_W    = 32;
    localparam int ACC_W     = 32;

    localparam logic [RATE_W-1:0]   RATE_RESET = 18'd44100;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 12'd4095;

    typedef enum logic [1:0] {
        EV_SONGPOS = 2'd0,
        EV_START   = 2'd1,
        EV_STOP    = 2'd2,
        EV_CLOCK   = 2'd3
    } event_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_ACC,
        S_LD2,
        S_DIV2,
        S_SPOS,
        S_START,
        S_STOP,
        S_CLK
    } gen_state_t;

endpackage

// File: hdl/midi_clock_generator.sv
// midi_clock_generator: 24 ppqn midi beat clock, song position, start and stop per audio block
// depends on midi_clk_pkg
//
// usage: one word on the input channel describes an audio block (length, playing flag, tempo,
// beat position). the block answers with zero or more event words on the output channel:
// song position then start when the transport starts, stop when it stops, then the clock
// pulses of the block with their sample offsets. last_event marks the final word of a block.
// sample_rate is written through cfg_we / cfg_wdata while the block is idle; the user must
// keep to this, as the block itself leaves it unenforced. in_ready is high only in the idle
// state. after an accepted word there is a multiply state, then the shared restoring divider
// (one quotient bit per cycle), an accumulate state, and when pulses are due a load state
// and another divider pass to get the pulse spacing. event words then go out one per cycle
// while the receiver takes them. the next word is accepted only once the final event word
// of the block has been issued.
// the output word sits in a register: a stalled receiver holds it and stalls only event
// emission; the next input word can be taken while the final word of a block still waits.
// reset clears the transport flag, the pulse accumulator and sample_rate to 44100.
module midi_clock_generator
    import midi_clk_pkg::*;
#(
    parameter int MAX_PULSES        = 62,
    parameter int ACC_FRACTION_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RATE_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BLOCK_W-1:0]  block_samples,
    input  logic                transport_playing,
    input  logic [TEMPO_W-1:0]  tempo_q8,
    input  logic [BEAT_W-1:0]   beat_position_q16,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          event_kind,
    output logic [POS_W-1:0]    song_position,
    output logic [OFFSET_W-1:0] sample_offset,
    output logic                last_event
);

    localparam int NUM_W = PROD_W + ACC_FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int PW    = $clog2(MAX_PULSES + 1);

    gen_state_t state_reg, state_next;

    logic [RATE_W-1:0]   sample_rate_reg, sample_rate_next;
    logic                was_playing_reg, was_playing_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;

    logic [BLOCK_W-1:0]  n_reg, n_next;
    logic [TEMPO_W-1:0]  tempo_reg, tempo_next;
    logic [POS_W-1:0]    spos_reg, spos_next;
    logic                playing_reg, playing_next;
    logic                rise_reg, rise_next;
    logic                fall_reg, fall_next;

    logic [NUM_W-1:0]    num_reg, num_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]   q_reg, q_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [PW-1:0]       whole_reg, whole_next;
    logic [PW-1:0]       pcnt_reg, pcnt_next;
    logic [PW-1:0]       frac_reg, frac_next;
    logic [BLOCK_W-1:0]  off_reg, off_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          event_kind_reg, event_kind_next;
    logic [POS_W-1:0]    song_position_reg, song_position_next;
    logic [OFFSET_W-1:0] sample_offset_reg, sample_offset_next;
    logic                last_event_reg, last_event_next;

    logic                in_fire;
    logic                slot_free;
    logic                div_active;
    logic                div_done;
    logic [DEN_W:0]      trial;
    logic                trial_ge;
    logic [DEN_W:0]      trial_diff;
    logic [RATE_W-1:0]   rate_eff;
    logic [PROD_W-1:0]   product;
    logic [ACC_W:0]      acc_sum;
    logic [ACC_W-1:0]    acc_sat;
    logic [ACC_W-1:0]    whole_raw;
    logic [PW-1:0]       whole_cap;
    logic                clk_last;
    logic [PW:0]         frac_sum;
    logic                frac_wrap;
    logic                hdr_last;
    gen_state_t          emit_entry;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign div_active = (state_reg == S_DIV) || (state_reg == S_DIV2);
    assign div_done   = (cnt_reg == CNT_W'(1));

    // shared restoring divider step
    assign trial      = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};

    assign rate_eff = (sample_rate_reg == '0) ? RATE_W'(1) : sample_rate_reg;
    assign product  = PROD_W'(tempo_reg) * PROD_W'(n_reg);

    assign acc_sum   = {1'b0, acc_reg} + {1'b0, q_reg};
    assign acc_sat   = (ovf_reg || acc_sum[ACC_W]) ? '1 : acc_sum[ACC_W-1:0];
    assign whole_raw = acc_sat >> ACC_FRACTION_BITS;
    assign whole_cap = (whole_raw > ACC_W'(MAX_PULSES)) ? PW'(MAX_PULSES) : whole_raw[PW-1:0];

    assign clk_last  = (pcnt_reg == whole_reg - PW'(1));
    assign frac_sum  = {1'b0, frac_reg} + {1'b0, rem_reg[PW-1:0]};
    assign frac_wrap = (frac_sum >= {1'b0, whole_reg});
    assign hdr_last  = (whole_reg == '0);

    always_comb
    begin
        if (rise_reg)
            emit_entry = S_SPOS;
        else if (fall_reg)
            emit_entry = S_STOP;
        else if (whole_reg != '0)
            emit_entry = S_CLK;
        else
            emit_entry = S_IDLE;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_MUL;
            end
            S_MUL:
                state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                if (playing_reg && whole_cap != '0)
                    state_next = S_LD2;
                else if (rise_reg)
                    state_next = S_SPOS;
                else if (fall_reg)
                    state_next = S_STOP;
                else
                    state_next = S_IDLE;
            end
            S_LD2:
                state_next = S_DIV2;
            S_DIV2:
            begin
                if (div_done)
                    state_next = emit_entry;
            end
            S_SPOS:
            begin
                if (slot_free)
                    state_next = S_START;
            end
            S_START, S_STOP:
            begin
                if (slot_free)
                    state_next = hdr_last ? S_IDLE : S_CLK;
            end
            S_CLK:
            begin
                if (slot_free && clk_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sample_rate_next   = cfg_we ? cfg_wdata : sample_rate_reg;
        was_playing_next   = was_playing_reg;
        acc_next           = acc_reg;
        n_next             = n_reg;
        tempo_next         = tempo_reg;
        spos_next          = spos_reg;
        playing_next       = playing_reg;
        rise_next          = rise_reg;
        fall_next          = fall_reg;
        num_next           = num_reg;
        den_next           = den_reg;
        rem_next           = rem_reg;
        q_next             = q_reg;
        ovf_next           = ovf_reg;
        cnt_next           = cnt_reg;
        whole_next         = whole_reg;
        pcnt_next          = pcnt_reg;
        frac_next          = frac_reg;
        off_next           = off_reg;
        out_valid_next     = out_ready ? 1'b0 : out_valid_reg;
        event_kind_next    = event_kind_reg;
        song_position_next = song_position_reg;
        sample_offset_next = sample_offset_reg;
        last_event_next    = last_event_reg;

        if (div_active)
        begin
            rem_next = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_next = num_reg << 1;
            q_next   = {q_reg[QUOT_W-2:0], trial_ge};
            ovf_next = ovf_reg || q_reg[QUOT_W-1];
            cnt_next = cnt_reg - CNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    n_next           = block_samples;
                    tempo_next       = tempo_q8;
                    spos_next        = beat_position_q16[BEAT_W-1 -: POS_W];
                    playing_next     = transport_playing;
                    rise_next        = transport_playing && !was_playing_reg;
                    fall_next        = !transport_playing && was_playing_reg;
                    was_playing_next = transport_playing;
                    whole_next       = '0;
                    if (transport_playing != was_playing_reg)
                        acc_next = '0;
                end
            end
            S_MUL:
            begin
                num_next = {product, (NUM_W - PROD_W)'(0)};
                den_next = DEN_W'({rate_eff, 10'd0}) + DEN_W'({rate_eff, 8'd0});
                rem_next = '0;
                q_next   = '0;
                ovf_next = 1'b0;
                cnt_next = CNT_W'(NUM_W);
            end
            S_ACC:
            begin
                if (playing_reg)
                begin
                    whole_next = whole_cap;
                    acc_next   = acc_sat - (ACC_W'(whole_cap) << ACC_FRACTION_BITS);
                end
            end
            S_LD2:
            begin
                num_next  = {n_reg, (NUM_W - BLOCK_W)'(0)};
                den_next  = DEN_W'(whole_reg);
                rem_next  = '0;
                q_next    = '0;
                ovf_next  = 1'b0;
                cnt_next  = CNT_W'(BLOCK_W);
                pcnt_next = '0;
                frac_next = '0;
                off_next  = '0;
            end
            S_SPOS:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    event_kind_next    = EV_SONGPOS;
                    song_position_next = spos_reg;
                    sample_offset_next = '0;
                    last_event_next    = 1'b0;
                end
            end
            S_START, S_STOP:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    event_kind_next    = (state_reg == S_START) ? EV_START : EV_STOP;
                    song_position_next = '0;
                    sample_offset_next = '0;
                    last_event_next    = hdr_last;
                end
            end
            S_CLK:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    event_kind_next    = EV_CLOCK;
                    song_position_next = '0;
                    sample_offset_next = off_reg[BLOCK_W-1] ? OFFSET_MAX
                                                            : off_reg[OFFSET_W-1:0];
                    last_event_next    = clk_last;
                    pcnt_next          = pcnt_reg + PW'(1);
                    // step offset by n/whole, carrying the remainder
                    frac_next = frac_wrap ? PW'(frac_sum - {1'b0, whole_reg}) : frac_sum[PW-1:0];
                    off_next  = off_reg + q_reg[BLOCK_W-1:0] + BLOCK_W'(frac_wrap);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sample_rate_reg <= RATE_RESET;
            was_playing_reg <= 1'b0;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sample_rate_reg <= sample_rate_next;
            was_playing_reg <= was_playing_next;
            acc_reg         <= acc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg             <= n_next;
        tempo_reg         <= tempo_next;
        spos_reg          <= spos_next;
        playing_reg       <= playing_next;
        rise_reg          <= rise_next;
        fall_reg          <= fall_next;
        num_reg           <= num_next;
        den_reg           <= den_next;
        rem_reg           <= rem_next;
        q_reg             <= q_next;
        ovf_reg           <= ovf_next;
        cnt_reg           <= cnt_next;
        whole_reg         <= whole_next;
        pcnt_reg          <= pcnt_next;
        frac_reg          <= frac_next;
        off_reg           <= off_next;
        event_kind_reg    <= event_kind_next;
        song_position_reg <= song_position_next;
        sample_offset_reg <= sample_offset_next;
        last_event_reg    <= last_event_next;
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = event_kind_reg;
    assign song_position = song_position_reg;
    assign sample_offset = sample_offset_reg;
    assign last_event    = last_event_reg;

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        div_active |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    // pulse counter and spacing remainder stay below the pulse count
    a_clk_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLK) |-> ((pcnt_reg < whole_reg) && (frac_reg < whole_reg)))
        else $error("clock pulse counter out of range");

    // pulse offsets never pass the block length
    a_clk_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLK) |-> (off_reg <= n_reg))
        else $error("clock pulse offset beyond block");

    // the final word of a block leaves the sequencer idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_free && ((state_reg == S_CLK && clk_last)
                       || ((state_reg == S_START || state_reg == S_STOP) && hdr_last)))
        |=> (state_reg == S_IDLE) && out_valid_reg && last_event_reg)
        else $error("final event did not end the block");

endmodule

// File: verif/midi_clock_event_checker.sv
// midi_clock_event_checker: predicts the event words of the midi beat clock generator
// from the accepted block words and checks the output channel against them
// depends on midi_clk_pkg
module midi_clock_event_checker
    import midi_clk_pkg::*;
#(
    parameter int MAX_PULSES        = 62,
    parameter int ACC_FRACTION_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RATE_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [BLOCK_W-1:0]  block_samples,
    input  logic                transport_playing,
    input  logic [TEMPO_W-1:0]  tempo_q8,
    input  logic [BEAT_W-1:0]   beat_position_q16,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          event_kind,
    input  logic [POS_W-1:0]    song_position,
    input  logic [OFFSET_W-1:0] sample_offset,
    input  logic                last_event,
    output int                  pending_events,
    output int                  fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        event_kind_t         kind;
        logic [POS_W-1:0]    pos;
        logic [OFFSET_W-1:0] offset;
        logic                last;
    } clock_event_t;

    clock_event_t      expected_events[$];
    logic [RATE_W-1:0] rate_reg;
    logic              transport_on;
    logic [ACC_W-1:0]  pulse_acc;
    int                errors;

    function automatic clock_event_t make_event(event_kind_t kind, logic [POS_W-1:0] pos,
                                                logic [OFFSET_W-1:0] off);
        clock_event_t ev;
        ev.kind = kind;
        ev.pos = pos;
        ev.offset = off;
        ev.last = 1'b0;
        return ev;
    endfunction

    task automatic predict_block(input logic [BLOCK_W-1:0] n, input logic playing,
                                 input logic [TEMPO_W-1:0] tempo, input logic [BEAT_W-1:0] beat);
        clock_event_t block_events[$];
        clock_event_t tail;
        logic [63:0]  rate;
        logic [63:0]  incr;
        logic [63:0]  sum;
        logic [63:0]  whole;
        logic [63:0]  off;
        logic [63:0]  p;
        if (playing && !transport_on)
        begin
            block_events.push_back(make_event(EV_SONGPOS, POS_W'(beat >> 14), '0));
            block_events.push_back(make_event(EV_START, '0, '0));
            pulse_acc = '0;
        end
        else if (!playing && transport_on)
        begin
            block_events.push_back(make_event(EV_STOP, '0, '0));
            pulse_acc = '0;
        end
        transport_on = playing;
        if (playing)
        begin
            rate = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
            incr = (64'(tempo) * 64'(n) * (64'd2 << ACC_FRACTION_BITS)) / (64'd1280 * rate);
            sum = 64'(pulse_acc) + incr;
            if (sum > 64'hFFFF_FFFF)
                sum = 64'hFFFF_FFFF;
            whole = sum >> ACC_FRACTION_BITS;
            if (whole > 64'(MAX_PULSES))
                whole = 64'(MAX_PULSES);
            sum = sum - (whole << ACC_FRACTION_BITS);
            pulse_acc = sum[ACC_W-1:0];
            for (p = 0; p < whole; p++)
            begin
                off = (p * 64'(n)) / whole;
                if (off > 64'(OFFSET_MAX))
                    off = 64'(OFFSET_MAX);
                block_events.push_back(make_event(EV_CLOCK, '0, off[OFFSET_W-1:0]));
            end
        end
        if (block_events.size() != 0)
        begin
            tail = block_events.pop_back();
            tail.last = 1'b1;
            block_events.push_back(tail);
        end
        foreach (block_events[i])
            expected_events.push_back(block_events[i]);
    endtask

    function automatic int field_diff(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_word();
        clock_event_t want;
        if (expected_events.size() == 0)
        begin
            $display("%0t: unexpected event word, expected none, actual kind %0d offset %0d",
                     $time, event_kind, sample_offset);
            errors++;
        end
        else
        begin
            want = expected_events.pop_front();
            errors += field_diff("event_kind", 32'(want.kind), 32'(event_kind));
            errors += field_diff("song_position", 32'(want.pos), 32'(song_position));
            errors += field_diff("sample_offset", 32'(want.offset), 32'(sample_offset));
            errors += field_diff("last_event", 32'(want.last), 32'(last_event));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg = RATE_RESET;
            transport_on = 1'b0;
            pulse_acc = '0;
            errors = 0;
            expected_events.delete();
            pending_events <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
                rate_reg = cfg_wdata;
            if (out_valid && out_ready)
                check_word();
            if (in_valid && in_ready)
                predict_block(block_samples, transport_playing, tempo_q8, beat_position_q16);
            pending_events <= expected_events.size();
            fail_count <= errors;
        end
    end

endmodule

// File: verif/midi_clock_generator_tb.sv
// midi_clock_generator_tb: drives audio block words and sample rate writes into the midi
// clock generator with random bursts and receiver stalls, and gives the verdict
// depends on midi_clk_pkg, midi_clock_generator and midi_clock_event_checker
module midi_clock_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import midi_clk_pkg::*;

    localparam int MAX_PULSES        = 62;
    localparam int ACC_FRACTION_BITS = 24;
    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int DRAIN_CYCLES      = 120;

    localparam logic [TEMPO_W-1:0] TEMPO_MAX = '1;
    localparam logic [TEMPO_W-1:0] TEMPO_120 = TEMPO_W'(120 * 256);
    localparam logic [BEAT_W-1:0]  BEAT_MAX  = '1;
    localparam logic [BLOCK_W-1:0] BLOCK_MAX = '1;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [RATE_W-1:0]   cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BLOCK_W-1:0]  block_samples = '0;
    logic                transport_playing = 1'b0;
    logic [TEMPO_W-1:0]  tempo_q8 = '0;
    logic [BEAT_W-1:0]   beat_position_q16 = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          event_kind;
    logic [POS_W-1:0]    song_position;
    logic [OFFSET_W-1:0] sample_offset;
    logic                last_event;
    int                  pending_events;
    int                  fail_count;

    int       cycle_count = 0;
    int       rx_count = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    int       burst_left = 0;
    logic     rand_playing = 1'b0;

    midi_clock_generator #(
        .MAX_PULSES        (MAX_PULSES),
        .ACC_FRACTION_BITS (ACC_FRACTION_BITS)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .block_samples     (block_samples),
        .transport_playing (transport_playing),
        .tempo_q8          (tempo_q8),
        .beat_position_q16 (beat_position_q16),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .event_kind        (event_kind),
        .song_position     (song_position),
        .sample_offset     (sample_offset),
        .last_event        (last_event)
    );

    midi_clock_event_checker #(
        .MAX_PULSES        (MAX_PULSES),
        .ACC_FRACTION_BITS (ACC_FRACTION_BITS)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .block_samples     (block_samples),
        .transport_playing (transport_playing),
        .tempo_q8          (tempo_q8),
        .beat_position_q16 (beat_position_q16),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .event_kind        (event_kind),
        .song_position     (song_position),
        .sample_offset     (sample_offset),
        .last_event        (last_event),
        .pending_events    (pending_events),
        .fail_count        (fail_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stall pattern, drawn at random from four modes
    always @(posedge clk)
    begin
        rx_count <= rx_count + 1;
        if (rx_count % 128 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:   out_ready <= 1'b1;
            RX_COIN:     out_ready <= ($urandom_range(0, 1) == 0);
            RX_PERIODIC: out_ready <= (rx_count % 4 == 0);
            default:     out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_block(input logic [BLOCK_W-1:0] n, input logic playing,
                              input logic [TEMPO_W-1:0] tempo, input logic [BEAT_W-1:0] beat);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        block_samples <= n;
        transport_playing <= playing;
        tempo_q8 <= tempo;
        beat_position_q16 <= beat;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_events();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_events != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_sample_rate(input logic [RATE_W-1:0] rate);
        drain_events();
        cfg_we <= 1'b1;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int words);
        logic [BLOCK_W-1:0] n;
        logic [TEMPO_W-1:0] tempo;
        logic [BEAT_W-1:0]  beat;
        logic [31:0]        rnd;
        for (int i = 0; i < words; i++)
        begin
            if (rand_playing)
            begin
                if ($urandom_range(0, 11) == 0)
                    rand_playing = 1'b0;
            end
            else if ($urandom_range(0, 2) == 0)
                rand_playing = 1'b1;
            rnd = $urandom();
            case ($urandom_range(0, 15))
                0:       n = '0;
                1:       n = BLOCK_MAX;
                2, 3:    n = rnd[BLOCK_W-1:0];
                default: n = BLOCK_W'($urandom_range(16, 1024));
            endcase
            rnd = $urandom();
            case ($urandom_range(0, 7))
                0:       tempo = rnd[TEMPO_W-1:0];
                1:       tempo = TEMPO_MAX;
                2:       tempo = '0;
                default: tempo = TEMPO_W'($urandom_range(40 * 256, 300 * 256));
            endcase
            rnd = $urandom();
            beat = rnd[BEAT_W-1:0];
            send_block(n, rand_playing, tempo, beat);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_block(13'd1, 1'b0, TEMPO_120, '0);
        send_block('0, 1'b1, TEMPO_MAX, BEAT_MAX);
        send_block(BLOCK_MAX, 1'b1, TEMPO_MAX, '0);
        send_block('0, 1'b1, TEMPO_MAX, '0);
        send_block(13'd4096, 1'b1, TEMPO_W'(256), BEAT_W'(28'h0004000));
        send_block(13'd512, 1'b0, TEMPO_120, '0);
        send_block(13'd512, 1'b0, TEMPO_120, '0);
        send_block(13'd4096, 1'b1, '0, BEAT_W'(28'h00C8000));
        repeat (4) send_block(13'd512, 1'b1, TEMPO_120, BEAT_W'(28'h0010000));
        send_block(13'd1, 1'b1, TEMPO_MAX, '0);
        send_block(13'd256, 1'b0, TEMPO_120, '0);

        write_sample_rate(RATE_W'(8000));
        run_random(60);
        write_sample_rate(RATE_W'(192000));
        run_random(60);
        // zero rate, accumulator saturates
        write_sample_rate('0);
        send_block(BLOCK_MAX, 1'b1, TEMPO_MAX, '0);
        send_block(BLOCK_MAX, 1'b1, TEMPO_MAX, '0);
        send_block(13'd64, 1'b1, TEMPO_120, '0);
        rand_playing = 1'b1;
        run_random(50);
        write_sample_rate('1);
        run_random(50);
        write_sample_rate(RATE_W'(48000));
        run_random(70);
        write_sample_rate(RATE_RESET);
        run_random(60);

        drain_events();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
